[rtl/morse_vibration_sequencer_defines.svh]
// Assertion macros shared by the checker of the Morse vibration sequencer.
// No dependencies; include by bare file name.
`ifndef MORSE_VIBRATION_SEQUENCER_DEFINES_SVH
`define MORSE_VIBRATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mvs_pkg.sv]
// Shared types, constants and helpers of the Morse vibration sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mvs_pkg;

    localparam int PATTERN_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;

    localparam int CFG_W       = 16;
    localparam int TIME_W      = 17;
    localparam int OP_W        = 3;
    localparam int SYM_W       = 8;
    localparam int PHASE_W     = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [TIME_W-1:0] ELAPSED_MAX = '1;

    localparam logic [SYM_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [SYM_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [CFG_W-1:0] DOT_RESET      = 16'd100;
    localparam logic [CFG_W-1:0] DASH_RESET     = 16'd300;
    localparam logic [CFG_W-1:0] SYM_GAP_RESET  = 16'd100;
    localparam logic [CFG_W-1:0] CHAR_GAP_RESET = 16'd300;
    localparam logic [CFG_W-1:0] NOTIFY_RESET   = 16'd500;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_APPEND = 3'd1,
        OP_START  = 3'd2,
        OP_NOTIFY = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE       = 3'd0,
        PH_NOTIFY     = 3'd1,
        PH_NOTIFY_GAP = 3'd2,
        PH_SYM_ON     = 3'd3,
        PH_SYM_GAP    = 3'd4,
        PH_CHAR_GAP   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        REG_DOT      = 3'd0,
        REG_DASH     = 3'd1,
        REG_SYM_GAP  = 3'd2,
        REG_CHAR_GAP = 3'd3,
        REG_NOTIFY   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        DUR_ZERO,
        DUR_DOT,
        DUR_DASH,
        DUR_SYM_GAP,
        DUR_CHAR_GAP,
        DUR_WORD_GAP,
        DUR_NOTIFY
    } dur_sel_t;

    typedef enum logic [2:0] {
        CLS_DOT,
        CLS_DASH,
        CLS_SPACE,
        CLS_SLASH,
        CLS_OTHER
    } sym_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PEEK_RD,
        ST_PEEK,
        ST_WALK_RD,
        ST_WALK,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] dot;
        logic [CFG_W-1:0] dash;
        logic [CFG_W-1:0] sym_gap;
        logic [CFG_W-1:0] char_gap;
        logic [CFG_W-1:0] notify;
    } cfg_t;

    typedef struct packed {
        logic     load_item;
        logic     tick;
        logic     append;
        logic     start;
        logic     clear;
        logic     advance;
        logic     go;
        phase_t   go_phase;
        dur_sel_t go_dur;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        phase_t          phase;
        logic            expire;
        logic            len_nonzero;
        logic            pos_lt_len;
        logic            store_full;
        sym_class_t      sym_class;
        logic            out_free;
    } dp_status_t;

    function automatic sym_class_t classify(input logic [SYM_W-1:0] b);
        sym_class_t c;
        case (b)
            CHAR_DOT:   c = CLS_DOT;
            CHAR_DASH:  c = CLS_DASH;
            CHAR_SPACE: c = CLS_SPACE;
            CHAR_SLASH: c = CLS_SLASH;
            default:    c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/morse_vibration_sequencer.sv]
// Top level of the Morse vibration sequencer: register file, controller, datapath.
// Depends on mvs_pkg, mvs_regs, mvs_ctrl and mvs_datapath.
//
//  channel | role          | payload
//  --------+---------------+---------------------------------------------
//  s_*     | command beats | tdata: op[2:0], symbol[10:3]
//  m_*     | status beats  | tdata: motor_on[0], busy_res[1], phase[4:2]
//  APB     | configuration | five 16-bit timing registers at 4*i
//
// A beat is accepted, executed, and then its result is loaded into the output
// register. A tick that ends a gap phase also walks the store, reading and then
// classifying each byte; one that ends a symbol first reads and peeks at the next
// byte, and walks on from it if it is not a dot or dash.
// A result not yet taken holds the next beat off.
// Reset is asynchronous; the pattern store holds no reset value.
`default_nettype none

module morse_vibration_sequencer
    import mvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[2:0], symbol[10:3], zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // motor_on[0], busy_res[1], phase[4:2]
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t st;

    mvs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mvs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/mvs_regs.sv]
// Configuration register file with an APB-style write/read port.
// Depends on mvs_pkg for the register map and reset values.
`default_nettype none

module mvs_regs
    import mvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot      <= DOT_RESET;
            cfg_reg.dash     <= DASH_RESET;
            cfg_reg.sym_gap  <= SYM_GAP_RESET;
            cfg_reg.char_gap <= CHAR_GAP_RESET;
            cfg_reg.notify   <= NOTIFY_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DOT:      cfg_reg.dot      <= pwdata[CFG_W-1:0];
                REG_DASH:     cfg_reg.dash     <= pwdata[CFG_W-1:0];
                REG_SYM_GAP:  cfg_reg.sym_gap  <= pwdata[CFG_W-1:0];
                REG_CHAR_GAP: cfg_reg.char_gap <= pwdata[CFG_W-1:0];
                REG_NOTIFY:   cfg_reg.notify   <= pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_DOT:      prdata = APB_DATA_W'(cfg_reg.dot);
            REG_DASH:     prdata = APB_DATA_W'(cfg_reg.dash);
            REG_SYM_GAP:  prdata = APB_DATA_W'(cfg_reg.sym_gap);
            REG_CHAR_GAP: prdata = APB_DATA_W'(cfg_reg.char_gap);
            REG_NOTIFY:   prdata = APB_DATA_W'(cfg_reg.notify);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/mvs_ctrl.sv]
// Sequencing state machine: decodes each beat and steps the datapath.
// Depends on mvs_pkg for state, command and status types.
`default_nettype none

module mvs_ctrl
    import mvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
                case (st.op)
                    OP_TICK:
                    begin
                        if (st.phase != PH_IDLE)
                        begin
                            cmd.tick = 1'b1;
                            if (st.expire)
                            begin
                                case (st.phase)
                                    PH_NOTIFY:
                                    begin
                                        cmd.go = 1'b1;
                                        if (st.len_nonzero)
                                        begin
                                            cmd.go_phase = PH_NOTIFY_GAP;
                                            cmd.go_dur   = DUR_CHAR_GAP;
                                        end
                                        else
                                        begin
                                            cmd.go_phase = PH_IDLE;
                                            cmd.go_dur   = DUR_ZERO;
                                        end
                                    end
                                    PH_SYM_ON:
                                    begin
                                        if (st.pos_lt_len)
                                        begin
                                            state_next = ST_PEEK_RD;
                                        end
                                        else
                                        begin
                                            cmd.go       = 1'b1;
                                            cmd.go_phase = PH_IDLE;
                                            cmd.go_dur   = DUR_ZERO;
                                        end
                                    end
                                    PH_NOTIFY_GAP, PH_SYM_GAP, PH_CHAR_GAP:
                                    begin
                                        state_next = ST_WALK_RD;
                                    end
                                    default:
                                    begin
                                        cmd.go       = 1'b1;
                                        cmd.go_phase = PH_IDLE;
                                        cmd.go_dur   = DUR_ZERO;
                                    end
                                endcase
                            end
                        end
                    end
                    OP_APPEND:
                    begin
                        cmd.append = (st.phase == PH_IDLE) && !st.store_full;
                    end
                    OP_START:
                    begin
                        cmd.start    = 1'b1;
                        cmd.go       = 1'b1;
                        cmd.go_phase = PH_NOTIFY;
                        cmd.go_dur   = DUR_NOTIFY;
                    end
                    OP_NOTIFY:
                    begin
                        cmd.clear    = 1'b1;
                        cmd.go       = 1'b1;
                        cmd.go_phase = PH_NOTIFY;
                        cmd.go_dur   = DUR_NOTIFY;
                    end
                    OP_STOP:
                    begin
                        cmd.clear    = 1'b1;
                        cmd.go       = 1'b1;
                        cmd.go_phase = PH_IDLE;
                        cmd.go_dur   = DUR_ZERO;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PEEK_RD:
            begin
                state_next = ST_PEEK;
            end
            ST_PEEK:
            begin
                // another on-symbol follows in this character: symbol gap
                if (st.sym_class inside {CLS_DOT, CLS_DASH})
                begin
                    cmd.go       = 1'b1;
                    cmd.go_phase = PH_SYM_GAP;
                    cmd.go_dur   = DUR_SYM_GAP;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    // fetched byte is still the one at the read position
                    state_next = ST_WALK;
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                state_next = ST_RESULT;
                if (st.pos_lt_len)
                begin
                    cmd.advance = 1'b1;
                    cmd.go      = 1'b1;
                    case (st.sym_class)
                        CLS_DOT:
                        begin
                            cmd.go_phase = PH_SYM_ON;
                            cmd.go_dur   = DUR_DOT;
                        end
                        CLS_DASH:
                        begin
                            cmd.go_phase = PH_SYM_ON;
                            cmd.go_dur   = DUR_DASH;
                        end
                        CLS_SPACE:
                        begin
                            cmd.go_phase = PH_CHAR_GAP;
                            cmd.go_dur   = DUR_CHAR_GAP;
                        end
                        CLS_SLASH:
                        begin
                            cmd.go_phase = PH_CHAR_GAP;
                            cmd.go_dur   = DUR_WORD_GAP;
                        end
                        default:
                        begin
                            // skip the byte and fetch the next one
                            cmd.go     = 1'b0;
                            state_next = ST_WALK_RD;
                        end
                    endcase
                end
                else
                begin
                    cmd.go       = 1'b1;
                    cmd.go_phase = PH_IDLE;
                    cmd.go_dur   = DUR_ZERO;
                end
            end
            ST_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/mvs_datapath.sv]
// Datapath: pattern store, phase timer, read/append pointers, output register.
// Depends on mvs_pkg; driven by mvs_ctrl commands, configured by mvs_regs.
`default_nettype none

module mvs_datapath
    import mvs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  dp_cmd_t                cmd,
    output dp_status_t             st,
    input  logic [IN_TDATA_W-1:0]  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic [SYM_W-1:0]       store_mem [PATTERN_DEPTH];
    logic [SYM_W-1:0]       rd_data_reg;

    logic [OP_W-1:0]        op_item_reg;
    logic [SYM_W-1:0]       sym_item_reg;

    phase_t                 phase_reg,    phase_next;
    logic [TIME_W-1:0]      elapsed_reg,  elapsed_next;
    logic [TIME_W-1:0]      duration_reg, duration_next;
    logic [CNT_W-1:0]       pos_reg,      pos_next;
    logic [CNT_W-1:0]       len_reg,      len_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [TIME_W-1:0]      elapsed_inc;
    logic [TIME_W-1:0]      go_dur;
    logic                   motor;

    // saturating millisecond count
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        case (cmd.go_dur)
            DUR_DOT:      go_dur = TIME_W'(cfg.dot);
            DUR_DASH:     go_dur = TIME_W'(cfg.dash);
            DUR_SYM_GAP:  go_dur = TIME_W'(cfg.sym_gap);
            DUR_CHAR_GAP: go_dur = TIME_W'(cfg.char_gap);
            DUR_WORD_GAP: go_dur = {cfg.char_gap, 1'b0};
            DUR_NOTIFY:   go_dur = TIME_W'(cfg.notify);
            default:      go_dur = '0;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        duration_next = duration_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;

        if (cmd.tick)
        begin
            elapsed_next = elapsed_inc;
        end
        if (cmd.append)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.start)
        begin
            len_next = cnt_reg;
            pos_next = '0;
        end
        if (cmd.clear)
        begin
            cnt_next = '0;
            len_next = '0;
            pos_next = '0;
        end
        if (cmd.advance)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (cmd.go)
        begin
            phase_next    = cmd.go_phase;
            elapsed_next  = '0;
            duration_next = go_dur;
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            duration_reg  <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            duration_reg  <= duration_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pattern store: one write port, one registered read port at the read position
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            store_mem[cnt_reg[ADDR_W-1:0]] <= sym_item_reg;
        end
        rd_data_reg <= store_mem[pos_reg[ADDR_W-1:0]];
    end

    assign motor = (phase_reg == PH_NOTIFY) || (phase_reg == PH_SYM_ON);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_item_reg  <= in_data[OP_W-1:0];
            sym_item_reg <= in_data[OP_W +: SYM_W];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{(OUT_TDATA_W-PHASE_W-2){1'b0}}, phase_reg,
                             phase_reg != PH_IDLE, motor};
        end
    end

    assign st.op          = op_item_reg;
    assign st.phase       = phase_reg;
    assign st.expire      = elapsed_inc >= duration_reg;
    assign st.len_nonzero = len_reg != '0;
    assign st.pos_lt_len  = pos_reg < len_reg;
    assign st.store_full  = cnt_reg >= CNT_W'(PATTERN_DEPTH);
    assign st.sym_class   = classify(rd_data_reg);
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/mvs_checker.sv]
// Port-level checker of the Morse vibration sequencer, bound to the top level.
// Depends on mvs_pkg and morse_vibration_sequencer_defines.svh.
`default_nettype none

`include "morse_vibration_sequencer_defines.svh"

module mvs_checker
    import mvs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // motor runs only in the notify and symbol-on phases
    `MVS_ASSERT_NOW(a_motor_phase, m_tvalid, m_tdata[0] == ((m_tdata[4:2] == PH_NOTIFY) || (m_tdata[4:2] == PH_SYM_ON)), "motor_on disagrees with phase")
    // busy flag mirrors a non-idle phase
    `MVS_ASSERT_NOW(a_busy_phase, m_tvalid, m_tdata[1] == (m_tdata[4:2] != PH_IDLE), "busy_res disagrees with phase")
    // ready is low in the cycle after each accepted beat
    `MVS_ASSERT_NEXT(a_no_ready_after_accept, s_tvalid && s_tready, !s_tready, "command accepted on back-to-back cycles")
    // a stalled result holds
    `MVS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind morse_vibration_sequencer mvs_checker u_mvs_checker (.*);

`default_nettype wire
